// ===== rtl/csl_pkg.sv =====
// shared types, token codes and character tables of the c subset tokenizer
package csl_pkg;

  // parameter defaults
  localparam int OFFSET_BITS_DEF = 32;
  localparam int LENGTH_BITS_DEF = 16;

  // token queue between front and back (power of two)
  localparam int QUEUE_DEPTH = 4;

  // result field widths
  localparam int KIND_W   = 6;
  localparam int START_W  = 32;
  localparam int LEN_W    = 16;
  localparam int VALUE_W  = 31;
  localparam int LINE_W   = 32;
  localparam int STATUS_W = 2;

  localparam logic [VALUE_W-1:0] INT_MAX_VALUE = '1;

  // token kinds
  localparam logic [KIND_W-1:0] K_INT_LIT   = 6'd0;
  localparam logic [KIND_W-1:0] K_IDENT     = 6'd1;
  localparam logic [KIND_W-1:0] K_KW_INT    = 6'd2;
  localparam logic [KIND_W-1:0] K_KW_RETURN = 6'd3;
  localparam logic [KIND_W-1:0] K_KW_IF     = 6'd4;
  localparam logic [KIND_W-1:0] K_KW_ELSE   = 6'd5;
  localparam logic [KIND_W-1:0] K_KW_WHILE  = 6'd6;
  localparam logic [KIND_W-1:0] K_PLUS      = 6'd7;
  localparam logic [KIND_W-1:0] K_MINUS     = 6'd8;
  localparam logic [KIND_W-1:0] K_STAR      = 6'd9;
  localparam logic [KIND_W-1:0] K_SLASH     = 6'd10;
  localparam logic [KIND_W-1:0] K_PERCENT   = 6'd11;
  localparam logic [KIND_W-1:0] K_ASSIGN    = 6'd12;
  localparam logic [KIND_W-1:0] K_EQ        = 6'd13;
  localparam logic [KIND_W-1:0] K_NE        = 6'd14;
  localparam logic [KIND_W-1:0] K_LT        = 6'd15;
  localparam logic [KIND_W-1:0] K_GT        = 6'd16;
  localparam logic [KIND_W-1:0] K_LE        = 6'd17;
  localparam logic [KIND_W-1:0] K_GE        = 6'd18;
  localparam logic [KIND_W-1:0] K_AMP       = 6'd19;
  localparam logic [KIND_W-1:0] K_PIPE      = 6'd20;
  localparam logic [KIND_W-1:0] K_CARET     = 6'd21;
  localparam logic [KIND_W-1:0] K_TILDE     = 6'd22;
  localparam logic [KIND_W-1:0] K_BANG      = 6'd23;
  localparam logic [KIND_W-1:0] K_LPAREN    = 6'd24;
  localparam logic [KIND_W-1:0] K_RPAREN    = 6'd25;
  localparam logic [KIND_W-1:0] K_LBRACE    = 6'd26;
  localparam logic [KIND_W-1:0] K_RBRACE    = 6'd27;
  localparam logic [KIND_W-1:0] K_SEMI      = 6'd28;
  localparam logic [KIND_W-1:0] K_COMMA     = 6'd29;
  localparam logic [KIND_W-1:0] K_AND_AND   = 6'd30;
  localparam logic [KIND_W-1:0] K_OR_OR     = 6'd31;
  localparam logic [KIND_W-1:0] K_PLUS_EQ   = 6'd32;
  localparam logic [KIND_W-1:0] K_MINUS_EQ  = 6'd33;
  localparam logic [KIND_W-1:0] K_INC       = 6'd34;
  localparam logic [KIND_W-1:0] K_DEC       = 6'd35;
  localparam logic [KIND_W-1:0] K_END       = 6'd36;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_UNKNOWN   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_TOO_LARGE = 2'd2;

  localparam int NUM_KEYWORDS = 5;

  typedef struct packed {
    logic [KIND_W-1:0]   kind;
    logic [START_W-1:0]  text_start;
    logic [LEN_W-1:0]    text_length;
    logic [VALUE_W-1:0]  int_value;
    logic [LINE_W-1:0]   line_number;
    logic [STATUS_W-1:0] status;
  } token_t;

  // all tokens caused by one input word
  typedef struct packed {
    logic   two;
    token_t first;
    token_t second;
  } bundle_t;

  typedef struct packed {
    logic              hit;
    logic [KIND_W-1:0] kind;
  } kind_hit_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z")) || (c == "_");
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == " ") || ((c >= 8'd9) && (c <= 8'd13));
  endfunction

  function automatic logic is_op_start(input logic [7:0] c);
    return (c == "+") || (c == "-") || (c == "=") || (c == "!") || (c == "<") ||
           (c == ">") || (c == "&") || (c == "|") || (c == "/");
  endfunction

  // keyword lengths: int, return, if, else, while
  function automatic logic [2:0] kw_len(input logic [2:0] k);
    logic [2:0] n;
    case (k)
      3'd0:    n = 3'd3;
      3'd1:    n = 3'd6;
      3'd2:    n = 3'd2;
      3'd3:    n = 3'd4;
      3'd4:    n = 3'd5;
      default: n = 3'd0;
    endcase
    return n;
  endfunction

  function automatic logic [7:0] kw_char(input logic [2:0] k, input logic [2:0] i);
    logic [7:0] ch;
    ch = 8'h00;
    case (k)
      3'd0: begin
        case (i)
          3'd0:    ch = "i";
          3'd1:    ch = "n";
          3'd2:    ch = "t";
          default: ch = 8'h00;
        endcase
      end
      3'd1: begin
        case (i)
          3'd0:    ch = "r";
          3'd1:    ch = "e";
          3'd2:    ch = "t";
          3'd3:    ch = "u";
          3'd4:    ch = "r";
          3'd5:    ch = "n";
          default: ch = 8'h00;
        endcase
      end
      3'd2: begin
        case (i)
          3'd0:    ch = "i";
          3'd1:    ch = "f";
          default: ch = 8'h00;
        endcase
      end
      3'd3: begin
        case (i)
          3'd0:    ch = "e";
          3'd1:    ch = "l";
          3'd2:    ch = "s";
          3'd3:    ch = "e";
          default: ch = 8'h00;
        endcase
      end
      3'd4: begin
        case (i)
          3'd0:    ch = "w";
          3'd1:    ch = "h";
          3'd2:    ch = "i";
          3'd3:    ch = "l";
          3'd4:    ch = "e";
          default: ch = 8'h00;
        endcase
      end
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  // pending operator that ends up standing alone
  function automatic logic [KIND_W-1:0] single_op(input logic [7:0] p);
    logic [KIND_W-1:0] k;
    case (p)
      "+":     k = K_PLUS;
      "-":     k = K_MINUS;
      "/":     k = K_SLASH;
      "=":     k = K_ASSIGN;
      "!":     k = K_BANG;
      "<":     k = K_LT;
      ">":     k = K_GT;
      "&":     k = K_AMP;
      default: k = K_PIPE;
    endcase
    return k;
  endfunction

  // two-character operators
  function automatic kind_hit_t pair_op(input logic [7:0] p, input logic [7:0] c);
    kind_hit_t r;
    r = '{hit: 1'b1, kind: K_END};
    if (p == "+" && c == "+")      r.kind = K_INC;
    else if (p == "+" && c == "=") r.kind = K_PLUS_EQ;
    else if (p == "-" && c == "-") r.kind = K_DEC;
    else if (p == "-" && c == "=") r.kind = K_MINUS_EQ;
    else if (p == "=" && c == "=") r.kind = K_EQ;
    else if (p == "!" && c == "=") r.kind = K_NE;
    else if (p == "<" && c == "=") r.kind = K_LE;
    else if (p == ">" && c == "=") r.kind = K_GE;
    else if (p == "&" && c == "&") r.kind = K_AND_AND;
    else if (p == "|" && c == "|") r.kind = K_OR_OR;
    else                           r.hit  = 1'b0;
    return r;
  endfunction

  // one-character tokens that never combine
  function automatic kind_hit_t punct_kind(input logic [7:0] c);
    kind_hit_t r;
    r.hit = 1'b1;
    case (c)
      "(":     r.kind = K_LPAREN;
      ")":     r.kind = K_RPAREN;
      "{":     r.kind = K_LBRACE;
      "}":     r.kind = K_RBRACE;
      ";":     r.kind = K_SEMI;
      ",":     r.kind = K_COMMA;
      "*":     r.kind = K_STAR;
      "%":     r.kind = K_PERCENT;
      "^":     r.kind = K_CARET;
      "~":     r.kind = K_TILDE;
      default: begin
        r.hit  = 1'b0;
        r.kind = K_END;
      end
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/csl_if.sv =====
// valid/ready channel interfaces for source bytes and tokens
interface csl_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_byte;
  logic       end_of_text;

  modport source (output valid, output char_byte, output end_of_text, input ready);
  modport sink (input valid, input char_byte, input end_of_text, output ready);
endinterface

interface csl_out_if import csl_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [KIND_W-1:0]   token_kind;
  logic [START_W-1:0]  text_start;
  logic [LEN_W-1:0]    text_length;
  logic [VALUE_W-1:0]  int_value;
  logic [LINE_W-1:0]   line_number;
  logic [STATUS_W-1:0] status;
  logic                last_of_run;

  modport source (output valid, output token_kind, output text_start, output text_length,
                  output int_value, output line_number, output status, output last_of_run,
                  input ready);
  modport sink (input valid, input token_kind, input text_start, input text_length,
                input int_value, input line_number, input status, input last_of_run,
                output ready);
endinterface

// ===== rtl/csl_front.sv =====
// scanner front: takes one source byte per cycle while the queue has room, keeps lexer state, builds token bundles
module csl_front import csl_pkg::*; #(
  parameter int OFFSET_BITS = OFFSET_BITS_DEF,
  parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  csl_in_if.sink        text,
  input  logic          q_ready,
  output logic          push,
  output bundle_t       push_data
);

  typedef enum logic [7:0] {
    M_IDLE  = 8'b0000_0001,
    M_NUM   = 8'b0000_0010,
    M_IDENT = 8'b0000_0100,
    M_OP    = 8'b0000_1000,
    M_LINE  = 8'b0001_0000,
    M_BLOCK = 8'b0010_0000,
    M_BSTAR = 8'b0100_0000,
    M_ERROR = 8'b1000_0000
  } mode_t;

  mode_t                    mode, mode_next;
  logic [7:0]               pend_op, pend_op_next;
  logic [VALUE_W-1:0]       acc, acc_next;
  logic                     ovf, ovf_next;
  logic [NUM_KEYWORDS-1:0]  cand, cand_next;
  logic [OFFSET_BITS-1:0]   tok_start, tok_start_next;
  logic [LENGTH_BITS-1:0]   tok_len, tok_len_next;
  logic [OFFSET_BITS-1:0]   stream_offset, stream_offset_next;
  logic [LINE_W-1:0]        line, line_next;

  logic                     accept;
  logic [7:0]               c;
  logic                     is_nl;
  logic [LINE_W-1:0]        line_inc;
  logic [LENGTH_BITS-1:0]   len_inc;
  logic [VALUE_W+3:0]       acc_mul;
  logic [NUM_KEYWORDS-1:0]  cand_step;
  logic [NUM_KEYWORDS-1:0]  cand_first;
  logic [KIND_W-1:0]        ident_kind;
  kind_hit_t                pair, punct;
  token_t                   flush_tok;
  logic                     flush_v;
  token_t                   e0, e1;
  logic                     e0_v, e1_v;
  logic                     restart;

  function automatic token_t mk_tok(input logic [KIND_W-1:0] kind,
                                    input logic [OFFSET_BITS-1:0] start,
                                    input logic [LENGTH_BITS-1:0] len,
                                    input logic [VALUE_W-1:0] val,
                                    input logic [LINE_W-1:0] ln,
                                    input logic [STATUS_W-1:0] st);
    token_t t;
    t.kind        = kind;
    t.text_start  = START_W'(start);
    t.text_length = LEN_W'(len);
    t.int_value   = val;
    t.line_number = ln;
    t.status      = st;
    return t;
  endfunction

  assign text.ready = q_ready;
  assign accept     = text.valid && q_ready;
  assign c          = text.char_byte;
  assign is_nl      = (c == 8'h0A);

  // saturating counters
  assign line_inc = (line == '1) ? line : line + 1'b1;
  assign len_inc  = (tok_len == '1) ? tok_len : tok_len + 1'b1;

  // decimal accumulate: acc * 10 + digit
  assign acc_mul = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {31'd0, c[3:0]};

  // keyword candidate filtering, one character position per byte
  always_comb begin
    for (int k = 0; k < NUM_KEYWORDS; k++) begin
      cand_step[k] = cand[k] && (tok_len < LENGTH_BITS'(kw_len(3'(k)))) &&
                     (kw_char(3'(k), tok_len[2:0]) == c);
      cand_first[k] = (kw_char(3'(k), 3'd0) == c);
    end
  end

  // keyword match at end of identifier, first keyword wins
  always_comb begin
    ident_kind = K_IDENT;
    for (int k = NUM_KEYWORDS - 1; k >= 0; k--) begin
      if (cand[k] && (tok_len == LENGTH_BITS'(kw_len(3'(k)))))
        ident_kind = K_KW_INT + KIND_W'(k);
    end
  end

  assign pair  = pair_op(pend_op, c);
  assign punct = punct_kind(c);

  // token pending in the current mode
  always_comb begin
    flush_v   = 1'b0;
    flush_tok = mk_tok(K_END, tok_start, tok_len, '0, line, ST_OK);
    case (mode)
      M_NUM: begin
        flush_v   = 1'b1;
        flush_tok = mk_tok(K_INT_LIT, tok_start, tok_len, acc, line,
                           ovf ? ST_TOO_LARGE : ST_OK);
      end
      M_IDENT: begin
        flush_v   = 1'b1;
        flush_tok = mk_tok(ident_kind, tok_start, tok_len, '0, line, ST_OK);
      end
      M_OP: begin
        flush_v   = 1'b1;
        flush_tok = mk_tok(single_op(pend_op), tok_start, LENGTH_BITS'(1), '0, line, ST_OK);
      end
      default: flush_v = 1'b0;
    endcase
  end

  // next lexer state and the tokens of this byte
  always_comb begin
    mode_next          = mode;
    pend_op_next       = pend_op;
    acc_next           = acc;
    ovf_next           = ovf;
    cand_next          = cand;
    tok_start_next     = tok_start;
    tok_len_next       = tok_len;
    stream_offset_next = stream_offset;
    line_next          = line;
    e0_v               = 1'b0;
    e0                 = flush_tok;
    e1_v               = 1'b0;
    e1                 = mk_tok(K_END, stream_offset, '0, '0, line, ST_OK);
    restart            = 1'b0;

    if (text.end_of_text) begin
      // flush, end token, then back to reset values
      e0_v               = flush_v;
      e1_v               = 1'b1;
      mode_next          = M_IDLE;
      pend_op_next       = '0;
      acc_next           = '0;
      ovf_next           = 1'b0;
      cand_next          = '1;
      tok_start_next     = '0;
      tok_len_next       = '0;
      stream_offset_next = '0;
      line_next          = LINE_W'(1);
    end else begin
      case (mode)
        M_ERROR: mode_next = M_ERROR;
        M_LINE: begin
          if (is_nl) begin
            line_next = line_inc;
            mode_next = M_IDLE;
          end
        end
        M_BLOCK: begin
          if (c == "*") mode_next = M_BSTAR;
          else if (is_nl) line_next = line_inc;
        end
        M_BSTAR: begin
          if (c == "/") begin
            mode_next = M_IDLE;
          end else if (c != "*") begin
            if (is_nl) line_next = line_inc;
            mode_next = M_BLOCK;
          end
        end
        M_OP: begin
          if (pend_op == "/" && c == "/") begin
            mode_next = M_LINE;
          end else if (pend_op == "/" && c == "*") begin
            mode_next = M_BLOCK;
          end else if (pair.hit) begin
            e0_v      = 1'b1;
            e0        = mk_tok(pair.kind, tok_start, LENGTH_BITS'(2), '0, line, ST_OK);
            mode_next = M_IDLE;
          end else begin
            e0_v    = 1'b1;
            restart = 1'b1;
          end
        end
        M_NUM: begin
          if (is_digit(c)) begin
            if (acc_mul > {4'b0000, INT_MAX_VALUE}) begin
              acc_next = INT_MAX_VALUE;
              ovf_next = 1'b1;
            end else begin
              acc_next = acc_mul[VALUE_W-1:0];
            end
            tok_len_next = len_inc;
          end else begin
            e0_v    = 1'b1;
            restart = 1'b1;
          end
        end
        M_IDENT: begin
          if (is_alpha(c) || is_digit(c)) begin
            cand_next    = cand_step;
            tok_len_next = len_inc;
          end else begin
            e0_v    = 1'b1;
            restart = 1'b1;
          end
        end
        default: restart = 1'b1;
      endcase

      // start of a new token at this byte
      if (restart) begin
        mode_next      = M_IDLE;
        tok_start_next = stream_offset;
        tok_len_next   = LENGTH_BITS'(1);
        if (is_space(c)) begin
          if (is_nl) line_next = line_inc;
        end else if (is_digit(c)) begin
          mode_next = M_NUM;
          acc_next  = VALUE_W'(c[3:0]);
          ovf_next  = 1'b0;
        end else if (is_alpha(c)) begin
          mode_next = M_IDENT;
          cand_next = cand_first;
        end else if (is_op_start(c)) begin
          mode_next    = M_OP;
          pend_op_next = c;
        end else if (punct.hit) begin
          e1_v = 1'b1;
          e1   = mk_tok(punct.kind, stream_offset, LENGTH_BITS'(1), '0, line, ST_OK);
        end else begin
          e1_v      = 1'b1;
          e1        = mk_tok(K_END, stream_offset, LENGTH_BITS'(1), '0, line, ST_UNKNOWN);
          mode_next = M_ERROR;
        end
      end

      // offset freezes once an unknown byte was seen
      if (mode != M_ERROR) stream_offset_next = stream_offset + 1'b1;
    end
  end

  // pack up to two tokens into one queue word
  assign push                = accept && (e0_v || e1_v);
  assign push_data.two       = e0_v && e1_v;
  assign push_data.first     = e0_v ? e0 : e1;
  assign push_data.second    = e1;

  // lexer state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= M_IDLE;
      pend_op       <= '0;
      acc           <= '0;
      ovf           <= 1'b0;
      cand          <= '1;
      tok_start     <= '0;
      tok_len       <= '0;
      stream_offset <= '0;
      line          <= LINE_W'(1);
    end else if (accept) begin
      mode          <= mode_next;
      pend_op       <= pend_op_next;
      acc           <= acc_next;
      ovf           <= ovf_next;
      cand          <= cand_next;
      tok_start     <= tok_start_next;
      tok_len       <= tok_len_next;
      stream_offset <= stream_offset_next;
      line          <= line_next;
    end
  end

`ifndef SYNTHESIS
  a_error_freezes_offset: assert property (@(posedge clk) disable iff (rst)
    (accept && !text.end_of_text && mode == M_ERROR) |=> $stable(stream_offset))
    else $error("offset moved after unknown byte");

  a_end_always_emits: assert property (@(posedge clk) disable iff (rst)
    (accept && text.end_of_text) |-> (push && (push_data.two || !flush_v)))
    else $error("end word lost a token");
`endif

endmodule

// ===== rtl/csl_queue.sv =====
// short queue of token bundles between scanner front and output back
module csl_queue import csl_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  bundle_t push_data,
  output logic    ready,
  input  logic    pop,
  output logic    head_valid,
  output bundle_t head_data
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  bundle_t           store [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr, rd_ptr;
  logic [CNT_W-1:0]  count;

  assign ready      = (count < CNT_W'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head_data  = store[rd_ptr];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) store[wr_ptr] <= push_data;
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (count < CNT_W'(QUEUE_DEPTH)))
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> (count != '0))
    else $error("pop from empty queue");
`endif

endmodule

// ===== rtl/csl_back.sv =====
// output back: holds one bundle and hands its tokens out one word at a time
module csl_back import csl_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      head_valid,
  input  bundle_t   head_data,
  output logic      pop,
  csl_out_if.source tokens
);

  bundle_t cur;
  logic    held;
  logic    idx;
  logic    last;
  logic    take;
  token_t  tok;

  assign last = !cur.two || idx;
  assign tok  = idx ? cur.second : cur.first;
  assign take = held && tokens.ready;
  assign pop  = head_valid && (!held || (take && last));

  // output word
  assign tokens.valid       = held;
  assign tokens.token_kind  = tok.kind;
  assign tokens.text_start  = tok.text_start;
  assign tokens.text_length = tok.text_length;
  assign tokens.int_value   = tok.int_value;
  assign tokens.line_number = tok.line_number;
  assign tokens.status      = tok.status;
  assign tokens.last_of_run = last;

  // hold state and token index
  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
      idx  <= 1'b0;
    end else if (pop) begin
      held <= 1'b1;
      idx  <= 1'b0;
    end else if (take) begin
      if (last) held <= 1'b0;
      else      idx  <= 1'b1;
    end
  end

  // bundle payload
  always_ff @(posedge clk) begin
    if (pop) cur <= head_data;
  end

`ifndef SYNTHESIS
  a_second_follows: assert property (@(posedge clk) disable iff (rst)
    (take && !last) |=> (tokens.valid && idx))
    else $error("second token of bundle dropped");
`endif

endmodule

// ===== rtl/c_subset_tokenizer.sv =====
// top level of the c subset tokenizer: scanner front, bundle queue, output back
//
//   channel  dir  handshake      payload
//   text     in   valid/ready    char_byte[7:0], end_of_text
//   tokens   out  valid/ready    token_kind, text_start, text_length, int_value,
//                                line_number, status, last_of_run
//
// one source byte is taken per cycle while the bundle queue has room; its tokens
// (zero, one or two) enter the four-deep queue at the same edge.
// the back delivers one token per cycle while tokens.ready is high; a byte
// giving two tokens is sent as two words, so the output port sets their rate.
// a token passes the queue store and then the output hold before it is offered.
// rst is synchronous and active high; it clears lexer state, queue and output hold.
// either side may stall freely; the queue decouples them.
module c_subset_tokenizer import csl_pkg::*; #(
  parameter int OFFSET_BITS = OFFSET_BITS_DEF,
  parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  csl_in_if.sink    text,
  csl_out_if.source tokens
);

  logic    q_ready;
  logic    push;
  bundle_t push_data;
  logic    pop;
  logic    head_valid;
  bundle_t head_data;

  csl_front #(
    .OFFSET_BITS (OFFSET_BITS),
    .LENGTH_BITS (LENGTH_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .text      (text),
    .q_ready   (q_ready),
    .push      (push),
    .push_data (push_data)
  );

  csl_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  (push_data),
    .ready      (q_ready),
    .pop        (pop),
    .head_valid (head_valid),
    .head_data  (head_data)
  );

  csl_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_data  (head_data),
    .pop        (pop),
    .tokens     (tokens)
  );

endmodule
